>>> sv/process_table_scheduler_assert.svh
// ----------------------------------------------------------------------------
// process table scheduler assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef PROCESS_TABLE_SCHEDULER_ASSERT_SVH
`define PROCESS_TABLE_SCHEDULER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define PTS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define PTS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg
// shared types and constants of the process table scheduler
// ----------------------------------------------------------------------------
`default_nettype none

package pts_pkg;

    // number of process slots, slot 0 is never allocated
    localparam int NUM_SLOTS = 16;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);

    localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(NUM_SLOTS - 1);
    localparam logic [SLOT_W-1:0] SLOT_FIRST = SLOT_W'(1);
    localparam logic signed [31:0] NUM_SLOTS_S = 32'(NUM_SLOTS);

    // answer codes
    localparam logic [31:0] RET_ERR  = 32'hFFFF_FFFF;
    localparam logic [31:0] RET_ONE  = 32'd1;
    localparam logic [31:0] RET_ZERO = 32'd0;

    // command codes
    typedef enum logic [2:0] {
        CMD_GETPID = 3'd0,
        CMD_FORK   = 3'd1,
        CMD_YIELD  = 3'd2,
        CMD_EXIT   = 3'd3,
        CMD_WAIT   = 3'd4,
        CMD_KILL   = 3'd5
    } cmd_t;

    // slot states
    typedef enum logic [1:0] {
        SLOT_EMPTY  = 2'd0,
        SLOT_RUN    = 2'd1,
        SLOT_BLOCK  = 2'd2,
        SLOT_ZOMBIE = 2'd3
    } slot_state_t;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_FORK_SCAN,
        S_EXIT_REC,
        S_WAKE,
        S_EXIT_FREE,
        S_WAIT_CHK,
        S_WAIT_BLOCK,
        S_KILL_CHK,
        S_SCHED,
        S_DONE
    } seq_state_t;

    // one write into the slot table, all fields at one slot
    typedef struct packed {
        logic              state_en;
        logic              status_en;
        logic              waiter_en;
        logic [SLOT_W-1:0] addr;
        slot_state_t       state;
        logic [31:0]       status;
        logic              wvalid;
        logic [SLOT_W-1:0] waiter;
    } tbl_wr_t;

    // one slot as read from the table
    typedef struct packed {
        slot_state_t       state;
        logic [31:0]       status;
        logic              wvalid;
        logic [SLOT_W-1:0] waiter;
    } tbl_rd_t;

endpackage

`default_nettype wire

>>> sv/pts_table.sv
// ----------------------------------------------------------------------------
// pts_table
// process slot table: state, exit status and waiter of every slot,
// one read address and one write address per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module pts_table (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [pts_pkg::SLOT_W-1:0]   rd_addr,
    output pts_pkg::tbl_rd_t                  rd,
    input  wire pts_pkg::tbl_wr_t             wr
);

    pts_pkg::slot_state_t              state_reg  [pts_pkg::NUM_SLOTS];
    logic [31:0]                       status_reg [pts_pkg::NUM_SLOTS];
    logic                              wvalid_reg [pts_pkg::NUM_SLOTS];
    logic [pts_pkg::SLOT_W-1:0]        waiter_reg [pts_pkg::NUM_SLOTS];

    // table write, slot one runnable after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < pts_pkg::NUM_SLOTS; i++)
            begin
                state_reg[i]  <= (i == 1) ? pts_pkg::SLOT_RUN : pts_pkg::SLOT_EMPTY;
                status_reg[i] <= '0;
                wvalid_reg[i] <= 1'b0;
                waiter_reg[i] <= '0;
            end
        end
        else
        begin
            if (wr.state_en)
            begin
                state_reg[wr.addr] <= wr.state;
            end
            if (wr.status_en)
            begin
                status_reg[wr.addr] <= wr.status;
            end
            if (wr.waiter_en)
            begin
                wvalid_reg[wr.addr] <= wr.wvalid;
                waiter_reg[wr.addr] <= wr.waiter;
            end
        end
    end

    // single read port
    always_comb
    begin
        rd.state  = state_reg[rd_addr];
        rd.status = status_reg[rd_addr];
        rd.wvalid = wvalid_reg[rd_addr];
        rd.waiter = waiter_reg[rd_addr];
    end

endmodule

`default_nettype wire

>>> sv/pts_seq.sv
// ----------------------------------------------------------------------------
// pts_seq
// command sequencer: walks the slot table one slot per cycle through a
// shared index stepper, holds the running process and the result word
// ----------------------------------------------------------------------------
`default_nettype none

module pts_seq (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // command channel
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [2:0]                  cmd,
    input  wire logic signed [31:0]          arg_value,
    // result channel
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic signed [31:0]               return_value,
    output logic                             caller_continues,
    output logic [3:0]                       next_process,
    output logic [3:0]                       woken_process,
    output logic signed [31:0]               woken_value,
    output logic                             no_runnable,
    // slot table port
    output logic [pts_pkg::SLOT_W-1:0]       rd_addr,
    input  wire pts_pkg::tbl_rd_t            rd,
    output pts_pkg::tbl_wr_t                 wr
);

    localparam int SW = pts_pkg::SLOT_W;

    pts_pkg::seq_state_t fsm_reg, fsm_next;
    logic [2:0]          cmd_reg, cmd_next;
    logic signed [31:0]  arg_reg, arg_next;
    logic [SW-1:0]       running_reg, running_next;
    logic [SW-1:0]       idx_reg, idx_next;
    logic [SW-1:0]       cnt_reg, cnt_next;
    logic [31:0]         ret_reg, ret_next;
    logic                cont_reg, cont_next;
    logic [SW-1:0]       who_reg, who_next;
    logic [31:0]         wval_reg, wval_next;
    logic                stuck_reg, stuck_next;
    logic                wk_valid_reg, wk_valid_next;
    logic [SW-1:0]       wk_pid_reg, wk_pid_next;

    logic                out_valid_reg, out_valid_next;
    logic [31:0]         o_ret_reg, o_ret_next;
    logic                o_cont_reg, o_cont_next;
    logic [SW-1:0]       o_next_reg, o_next_next;
    logic [SW-1:0]       o_who_reg, o_who_next;
    logic [31:0]         o_wval_reg, o_wval_next;
    logic                o_stuck_reg, o_stuck_next;

    logic [SW-1:0]       step_in;
    logic [SW-1:0]       step_out;
    logic [SW-1:0]       tgt;
    logic                arg_bad;

    // shared index stepper, wraps at the last slot
    assign step_out = (step_in == pts_pkg::SLOT_LAST) ? '0 : step_in + SW'(1);

    // target slot checks for wait and kill
    assign tgt     = arg_reg[SW-1:0];
    assign arg_bad = (arg_reg <= 32'sd0) || (arg_reg >= pts_pkg::NUM_SLOTS_S) ||
                     (tgt == running_reg);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg       <= pts_pkg::S_IDLE;
            running_reg   <= pts_pkg::SLOT_FIRST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fsm_reg       <= fsm_next;
            running_reg   <= running_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working and result registers
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        arg_reg      <= arg_next;
        idx_reg      <= idx_next;
        cnt_reg      <= cnt_next;
        ret_reg      <= ret_next;
        cont_reg     <= cont_next;
        who_reg      <= who_next;
        wval_reg     <= wval_next;
        stuck_reg    <= stuck_next;
        wk_valid_reg <= wk_valid_next;
        wk_pid_reg   <= wk_pid_next;
        o_ret_reg    <= o_ret_next;
        o_cont_reg   <= o_cont_next;
        o_next_reg   <= o_next_next;
        o_who_reg    <= o_who_next;
        o_wval_reg   <= o_wval_next;
        o_stuck_reg  <= o_stuck_next;
    end

    // sequencer next state and table access
    always_comb
    begin
        fsm_next       = fsm_reg;
        cmd_next       = cmd_reg;
        arg_next       = arg_reg;
        running_next   = running_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        ret_next       = ret_reg;
        cont_next      = cont_reg;
        who_next       = who_reg;
        wval_next      = wval_reg;
        stuck_next     = stuck_reg;
        wk_valid_next  = wk_valid_reg;
        wk_pid_next    = wk_pid_reg;
        out_valid_next = out_valid_reg && out_stall;
        o_ret_next     = o_ret_reg;
        o_cont_next    = o_cont_reg;
        o_next_next    = o_next_reg;
        o_who_next     = o_who_reg;
        o_wval_next    = o_wval_reg;
        o_stuck_next   = o_stuck_reg;

        rd_addr        = running_reg;
        step_in        = running_reg;
        wr             = '0;
        wr.addr        = running_reg;

        unique case (fsm_reg)
            pts_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next      = cmd;
                    arg_next      = arg_value;
                    ret_next      = pts_pkg::RET_ZERO;
                    cont_next     = 1'b1;
                    who_next      = '0;
                    wval_next     = '0;
                    stuck_next    = 1'b0;
                    wk_valid_next = 1'b0;
                    idx_next      = step_out;
                    cnt_next      = '0;
                    unique case (cmd)
                        pts_pkg::CMD_GETPID:
                        begin
                            ret_next = 32'(running_reg);
                            fsm_next = pts_pkg::S_DONE;
                        end
                        pts_pkg::CMD_FORK:
                        begin
                            ret_next = pts_pkg::RET_ERR;
                            idx_next = pts_pkg::SLOT_FIRST;
                            fsm_next = pts_pkg::S_FORK_SCAN;
                        end
                        pts_pkg::CMD_YIELD:
                        begin
                            cont_next = 1'b0;
                            fsm_next  = pts_pkg::S_SCHED;
                        end
                        pts_pkg::CMD_EXIT:
                        begin
                            cont_next = 1'b0;
                            fsm_next  = pts_pkg::S_EXIT_REC;
                        end
                        pts_pkg::CMD_WAIT:
                        begin
                            fsm_next = pts_pkg::S_WAIT_CHK;
                        end
                        pts_pkg::CMD_KILL:
                        begin
                            fsm_next = pts_pkg::S_KILL_CHK;
                        end
                        default:
                        begin
                            fsm_next = pts_pkg::S_DONE;
                        end
                    endcase
                end
            end

            // lowest empty slot from one upward
            pts_pkg::S_FORK_SCAN:
            begin
                rd_addr = idx_reg;
                step_in = idx_reg;
                if (rd.state == pts_pkg::SLOT_EMPTY)
                begin
                    wr.state_en = 1'b1;
                    wr.addr     = idx_reg;
                    wr.state    = pts_pkg::SLOT_RUN;
                    ret_next    = 32'(idx_reg);
                    fsm_next    = pts_pkg::S_DONE;
                end
                else if (idx_reg == pts_pkg::SLOT_LAST)
                begin
                    fsm_next = pts_pkg::S_DONE;
                end
                else
                begin
                    idx_next = step_out;
                end
            end

            // record status, pick up and clear the waiter
            pts_pkg::S_EXIT_REC:
            begin
                wr.status_en  = 1'b1;
                wr.waiter_en  = 1'b1;
                wr.status     = arg_reg;
                wk_valid_next = rd.wvalid;
                wk_pid_next   = rd.waiter;
                if (rd.wvalid)
                begin
                    who_next  = rd.waiter;
                    wval_next = arg_reg;
                end
                fsm_next = pts_pkg::S_WAKE;
            end

            // make the recorded waiter runnable
            pts_pkg::S_WAKE:
            begin
                if (wk_valid_reg)
                begin
                    wr.state_en = 1'b1;
                    wr.addr     = wk_pid_reg;
                    wr.state    = pts_pkg::SLOT_RUN;
                end
                if (cmd_reg == pts_pkg::CMD_EXIT)
                begin
                    fsm_next = pts_pkg::S_EXIT_FREE;
                end
                else
                begin
                    fsm_next = pts_pkg::S_DONE;
                end
            end

            pts_pkg::S_EXIT_FREE:
            begin
                wr.state_en = 1'b1;
                wr.state    = pts_pkg::SLOT_EMPTY;
                fsm_next    = pts_pkg::S_SCHED;
            end

            // reap, reject or block on the target
            pts_pkg::S_WAIT_CHK:
            begin
                rd_addr = tgt;
                wr.addr = tgt;
                if (arg_bad || rd.state == pts_pkg::SLOT_EMPTY)
                begin
                    ret_next = pts_pkg::RET_ERR;
                    fsm_next = pts_pkg::S_SCHED;
                end
                else if (rd.state == pts_pkg::SLOT_ZOMBIE)
                begin
                    ret_next    = rd.status;
                    wr.state_en = 1'b1;
                    wr.state    = pts_pkg::SLOT_EMPTY;
                    fsm_next    = pts_pkg::S_SCHED;
                end
                else
                begin
                    wr.waiter_en = 1'b1;
                    wr.wvalid    = 1'b1;
                    wr.waiter    = running_reg;
                    cont_next    = 1'b0;
                    fsm_next     = pts_pkg::S_WAIT_BLOCK;
                end
            end

            pts_pkg::S_WAIT_BLOCK:
            begin
                wr.state_en = 1'b1;
                wr.state    = pts_pkg::SLOT_BLOCK;
                fsm_next    = pts_pkg::S_SCHED;
            end

            // free the target and pick up its waiter, or reject a bad target
            pts_pkg::S_KILL_CHK:
            begin
                rd_addr = tgt;
                wr.addr = tgt;
                if (arg_bad)
                begin
                    ret_next = pts_pkg::RET_ERR;
                    fsm_next = pts_pkg::S_DONE;
                end
                else if (rd.state == pts_pkg::SLOT_EMPTY)
                begin
                    ret_next = pts_pkg::RET_ONE;
                    fsm_next = pts_pkg::S_DONE;
                end
                else
                begin
                    ret_next      = pts_pkg::RET_ONE;
                    wr.state_en   = 1'b1;
                    wr.status_en  = 1'b1;
                    wr.waiter_en  = 1'b1;
                    wr.state      = pts_pkg::SLOT_EMPTY;
                    wr.status     = 32'(tgt);
                    wk_valid_next = rd.wvalid;
                    wk_pid_next   = rd.waiter;
                    if (rd.wvalid)
                    begin
                        who_next  = rd.waiter;
                        wval_next = 32'(tgt);
                    end
                    fsm_next = pts_pkg::S_WAKE;
                end
            end

            // round-robin scan from the slot after the running one
            pts_pkg::S_SCHED:
            begin
                rd_addr = idx_reg;
                step_in = idx_reg;
                if (rd.state == pts_pkg::SLOT_RUN)
                begin
                    running_next = idx_reg;
                    fsm_next     = pts_pkg::S_DONE;
                end
                else if (cnt_reg == pts_pkg::SLOT_LAST)
                begin
                    stuck_next = 1'b1;
                    fsm_next   = pts_pkg::S_DONE;
                end
                else
                begin
                    idx_next = step_out;
                    cnt_next = cnt_reg + SW'(1);
                end
            end

            // hand the result word to the output register
            pts_pkg::S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    o_ret_next     = ret_reg;
                    o_cont_next    = cont_reg;
                    o_next_next    = running_reg;
                    o_who_next     = who_reg;
                    o_wval_next    = wval_reg;
                    o_stuck_next   = stuck_reg;
                    fsm_next       = pts_pkg::S_IDLE;
                end
            end

            default:
            begin
                fsm_next = pts_pkg::S_IDLE;
            end
        endcase
    end

    // ports
    assign in_stall         = (fsm_reg != pts_pkg::S_IDLE);
    assign out_valid        = out_valid_reg;
    assign return_value     = o_ret_reg;
    assign caller_continues = o_cont_reg;
    assign next_process     = 4'(o_next_reg);
    assign woken_process    = 4'(o_who_reg);
    assign woken_value      = o_wval_reg;
    assign no_runnable      = o_stuck_reg;

endmodule

`default_nettype wire

>>> sv/process_table_scheduler.sv
// ----------------------------------------------------------------------------
// process_table_scheduler
// process table and round-robin scheduler, one command word in, one result
// word out
// ----------------------------------------------------------------------------
// One command is worked on at a time; in_stall is high from the cycle after
// acceptance until the result is placed in the output register, and a new
// command may be taken while that result still waits under out_stall. Every
// slot access goes through a single table port, one slot per cycle, so the
// cost is set by the slot scans: fork searches from slot 1 upward for the
// lowest empty slot, and yield, exit and wait end in a round-robin scan
// after their table updates, while getpid, kill and unknown codes scan no
// slots. Slot 0 is never allocated, and slot 1 is the running process after
// reset.
`default_nettype none

module process_table_scheduler (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [2:0]          cmd,
    input  wire logic signed [31:0]  arg_value,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic signed [31:0]       return_value,
    output logic                     caller_continues,
    output logic [3:0]               next_process,
    output logic [3:0]               woken_process,
    output logic signed [31:0]       woken_value,
    output logic                     no_runnable
);

    logic [pts_pkg::SLOT_W-1:0] rd_addr;
    pts_pkg::tbl_rd_t           rd;
    pts_pkg::tbl_wr_t           wr;

    // command sequencer
    pts_seq u_seq (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .cmd              (cmd),
        .arg_value        (arg_value),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .return_value     (return_value),
        .caller_continues (caller_continues),
        .next_process     (next_process),
        .woken_process    (woken_process),
        .woken_value      (woken_value),
        .no_runnable      (no_runnable),
        .rd_addr          (rd_addr),
        .rd               (rd),
        .wr               (wr)
    );

    // slot table
    pts_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (rd_addr),
        .rd      (rd),
        .wr      (wr)
    );

endmodule

`default_nettype wire

>>> sv/pts_checker.sv
// ----------------------------------------------------------------------------
// pts_checker
// port-level checks of the process table scheduler, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "process_table_scheduler_assert.svh"

module pts_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_stall,
    input wire logic [2:0]          cmd,
    input wire logic signed [31:0]  arg_value,
    input wire logic                out_valid,
    input wire logic                out_stall,
    input wire logic signed [31:0]  return_value,
    input wire logic                caller_continues,
    input wire logic [3:0]          next_process,
    input wire logic [3:0]          woken_process,
    input wire logic signed [31:0]  woken_value,
    input wire logic                no_runnable
);

    // a stalled command word holds
    `PTS_ASSERT_NXT(a_in_hold, in_valid && in_stall,
        in_valid && $stable(cmd) && $stable(arg_value), "stalled command word changed")

    // a stalled result word holds
    `PTS_ASSERT_NXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(return_value) && $stable(caller_continues) &&
        $stable(next_process) && $stable(woken_process) && $stable(woken_value) &&
        $stable(no_runnable), "stalled result word changed")

    // a caller that does not continue gets no value
    `PTS_ASSERT_IMP(a_blocked_ret, out_valid && !caller_continues,
        return_value == 32'sd0, "value returned to a caller that does not continue")

    // no woken process means no delivered status
    `PTS_ASSERT_IMP(a_wake_value, out_valid && woken_process == 4'd0,
        woken_value == 32'sd0, "woken value without a woken process")

    // slot zero never runs
    `PTS_ASSERT_IMP(a_no_slot_zero, out_valid, next_process != 4'd0,
        "slot zero reported as running")

endmodule

bind process_table_scheduler pts_checker u_pts_checker (.*);

`default_nettype wire
